// ===== rtl/core/i2c_bit_bang_master_defines.svh =====
// Assertion macros shared by the checker of the I2C bit-level master.
// No dependencies; the using file supplies clk and arst_n in its scope.
`ifndef I2C_BIT_BANG_MASTER_DEFINES_SVH
`define I2C_BIT_BANG_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CBB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cbb_pkg.sv =====
// Types and constants of the I2C bit-level master.
// No dependencies.
package i2cbb_pkg;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_START   = 3'd1,
		OP_RESTART = 3'd2,
		OP_STOP    = 3'd3,
		OP_WRITE   = 3'd4,
		OP_READ    = 3'd5,
		OP_ACK     = 3'd6,
		OP_NACK    = 3'd7
	} op_t;

	typedef struct packed {
		logic sda_drv;
		logic sda_lvl;
		logic scl_drv;
		logic scl_lvl;
	} pins_t;

	typedef struct packed {
		pins_t      pins;
		logic [7:0] shift;
	} act_t;

	localparam logic [2:0] ACK_WAIT_PHASE = 3'd4;
	localparam logic [2:0] ACK_DONE_PHASE = 3'd5;
	localparam logic [2:0] READ_END_PHASE = 3'd4;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
	localparam logic [2:0] TOP_BIT        = 3'd7;

endpackage

// ===== rtl/core/i2c_bit_bang_master.sv =====
// I2C bit-level master engine: top level with its phase sequencer.
// Depends on i2cbb_pkg.
//
// One request is one tick of the bus phase timer and yields exactly one result. A request
// is taken every clock while the result side drains; a request passes an input register
// and the sequencer logic into the result register, from which its result is offered.
// A full result register held by out_stall stalls the input side.
module i2c_bit_bang_master
	import i2cbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       scl_drive,
	output logic       sda_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic       ack_waiting,
	output logic [7:0] read_data
);

	logic       advance;
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] wdata_s1;
	logic       sda_s1;

	logic [7:0] phase_length_q;
	op_t        cmd_q, cmd_n;
	logic [2:0] phase_q, phase_n;
	logic [3:0] bits_q, bits_n;
	logic [7:0] tick_q, tick_n;
	logic [7:0] shift_q, shift_n;
	pins_t      pins_q, pins_n;
	logic [7:0] hold_q, hold_n;
	logic       done_n;
	logic [7:0] len;

	function automatic act_t do_action(op_t cmd, logic [2:0] p, logic [3:0] bc,
		logic [7:0] shift, pins_t pins, logic sda);
		act_t       r;
		logic [2:0] sh;
		r.pins  = pins;
		r.shift = shift;
		sh      = TOP_BIT - bc[2:0];
		case (cmd)
			OP_START: begin
				case (p)
					3'd0:    r.pins.sda_lvl = 1'b1;
					3'd1:    r.pins.scl_lvl = 1'b1;
					3'd2:    r.pins.sda_drv = 1'b1;
					3'd3:    r.pins.scl_drv = 1'b1;
					default: r.pins.sda_lvl = 1'b0;
				endcase
			end
			OP_RESTART, OP_STOP: begin
				case (p)
					3'd0:    r.pins.scl_lvl = 1'b0;
					3'd1:    r.pins.sda_lvl = (cmd == OP_RESTART);
					3'd2:    r.pins.scl_lvl = 1'b1;
					default: r.pins.sda_lvl = (cmd != OP_RESTART);
				endcase
			end
			OP_NACK: begin
				case (p)
					3'd0:    r.pins.scl_lvl = 1'b0;
					3'd1:    r.pins.sda_lvl = 1'b1;
					default: r.pins.scl_lvl = 1'b1;
				endcase
			end
			OP_WRITE: begin
				case (p)
					3'd0:    r.pins.scl_lvl = 1'b0;
					3'd1:    r.pins.sda_lvl = shift[sh];
					default: r.pins.scl_lvl = 1'b1;
				endcase
			end
			OP_READ: begin
				case (p)
					3'd0:    r.pins.sda_drv = 1'b0;
					3'd1:    r.pins.scl_lvl = 1'b0;
					3'd2:    r.pins.scl_lvl = 1'b1;
					3'd3:    r.shift[sh]    = sda;
					default: r.pins.sda_drv = 1'b1;
				endcase
			end
			OP_ACK: begin
				case (p)
					3'd0:    r.pins.scl_lvl = 1'b0;
					3'd1:    r.pins.sda_lvl = 1'b1;
					3'd2:    r.pins.sda_drv = 1'b0;
					3'd3:    r.pins.scl_lvl = 1'b1;
					3'd5:    r.pins.sda_drv = 1'b1;
					default: r.pins.sda_drv = pins.sda_drv;
				endcase
			end
			default: r.pins = pins;
		endcase
		return r;
	endfunction

	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign len      = (phase_length_q == 8'd0) ? 8'd1 : phase_length_q;

	always_comb begin
		act_t a;
		logic enter;
		logic cont;
		cmd_n   = cmd_q;
		phase_n = phase_q;
		bits_n  = bits_q;
		tick_n  = tick_q;
		shift_n = shift_q;
		pins_n  = pins_q;
		hold_n  = hold_q;
		done_n  = 1'b0;
		enter   = 1'b0;
		cont    = 1'b0;
		a       = '0;
		if (cmd_q == OP_NONE) begin
			if (op_s1 != OP_NONE) begin
				cmd_n   = op_s1;
				phase_n = 3'd0;
				bits_n  = 4'd0;
				if (op_s1 == OP_WRITE) begin
					shift_n = wdata_s1;
				end
				enter = 1'b1;
			end
		end else if (cmd_q == OP_ACK && phase_q == ACK_WAIT_PHASE) begin
			if (!sda_s1) begin
				phase_n        = ACK_DONE_PHASE;
				tick_n         = 8'd0;
				pins_n.sda_drv = 1'b1;
			end
		end else if ({1'b0, tick_q} + 9'd1 >= {1'b0, len}) begin
			case (cmd_q)
				OP_WRITE: begin
					if (phase_q >= 3'd2) begin
						phase_n = 3'd0;
						bits_n  = bits_q + 4'd1;
						cont    = (bits_n < BITS_PER_BYTE);
					end else begin
						phase_n = phase_q + 3'd1;
						cont    = 1'b1;
					end
				end
				OP_READ: begin
					if (phase_q == 3'd3) begin
						bits_n  = bits_q + 4'd1;
						phase_n = (bits_n < BITS_PER_BYTE) ? 3'd1 : READ_END_PHASE;
						cont    = 1'b1;
					end else begin
						phase_n = phase_q + 3'd1;
						cont    = (phase_q < READ_END_PHASE);
					end
				end
				OP_START: begin
					phase_n = phase_q + 3'd1;
					cont    = (phase_q < 3'd4);
				end
				OP_RESTART, OP_STOP: begin
					phase_n = phase_q + 3'd1;
					cont    = (phase_q < 3'd3);
				end
				OP_NACK: begin
					phase_n = phase_q + 3'd1;
					cont    = (phase_q < 3'd2);
				end
				OP_ACK: begin
					phase_n = phase_q + 3'd1;
					cont    = (phase_q < ACK_DONE_PHASE);
				end
				default: cont = 1'b0;
			endcase
			if (cont) begin
				enter = 1'b1;
			end else begin
				if (cmd_q == OP_READ) begin
					hold_n = shift_q;
				end
				cmd_n   = OP_NONE;
				phase_n = 3'd0;
				bits_n  = 4'd0;
				tick_n  = 8'd0;
				done_n  = 1'b1;
			end
		end else begin
			tick_n = tick_q + 8'd1;
		end
		if (enter) begin
			tick_n  = 8'd0;
			a       = do_action(cmd_n, phase_n, bits_n, shift_n, pins_n, sda_s1);
			pins_n  = a.pins;
			shift_n = a.shift;
			if (cmd_n == OP_ACK && phase_n == ACK_WAIT_PHASE && !sda_s1) begin
				phase_n        = ACK_DONE_PHASE;
				pins_n.sda_drv = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= 8'd1;
			valid_s1       <= 1'b0;
			out_valid      <= 1'b0;
			cmd_q          <= OP_NONE;
			phase_q        <= 3'd0;
			bits_q         <= 4'd0;
			tick_q         <= 8'd0;
			shift_q        <= 8'd0;
			pins_q         <= '0;
			hold_q         <= 8'd0;
		end else begin
			if (cfg_wr_en) begin
				phase_length_q <= cfg_wr_data;
			end
			if (advance) begin
				valid_s1  <= in_valid;
				out_valid <= valid_s1;
				if (valid_s1) begin
					cmd_q   <= cmd_n;
					phase_q <= phase_n;
					bits_q  <= bits_n;
					tick_q  <= tick_n;
					shift_q <= shift_n;
					pins_q  <= pins_n;
					hold_q  <= hold_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1    <= op_t'(operation);
			wdata_s1 <= write_data;
			sda_s1   <= sda_in;
			if (valid_s1) begin
				scl_level   <= pins_n.scl_lvl;
				scl_drive   <= pins_n.scl_drv;
				sda_level   <= pins_n.sda_lvl;
				sda_drive   <= pins_n.sda_drv;
				busy_res    <= (cmd_n != OP_NONE);
				done_res    <= done_n;
				ack_waiting <= (cmd_n == OP_ACK && phase_n == ACK_WAIT_PHASE);
				read_data   <= hold_n;
			end
		end
	end

endmodule

// ===== rtl/core/i2cbb_checker.sv =====
// Port-level checker for the I2C bit-level master, bound to the top level.
// Depends on i2c_bit_bang_master_defines.svh.
`include "i2c_bit_bang_master_defines.svh"

module i2cbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       scl_drive,
	input logic       sda_level,
	input logic       sda_drive,
	input logic       busy_res,
	input logic       done_res,
	input logic       ack_waiting,
	input logic [7:0] read_data
);

	// A finished command leaves the engine idle.
	`I2CBB_ASSERT_SAME(a_done_idle, out_valid && done_res, !busy_res, "done while busy")
	// While waiting for acknowledge, SDA is released and SCL is high.
	`I2CBB_ASSERT_SAME(a_ack_bus, out_valid && ack_waiting,
		busy_res && !sda_drive && scl_level, "bad bus state in acknowledge wait")
	// A stalled result holds.
	`I2CBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(read_data) && $stable(done_res) && $stable(busy_res)
		&& $stable(scl_level) && $stable(scl_drive) && $stable(sda_level)
		&& $stable(sda_drive) && $stable(ack_waiting), "stalled result changed")

endmodule

bind i2c_bit_bang_master i2cbb_checker u_i2cbb_checker (.*);

// ===== verif/tb_i2c_bit_bang_master.sv =====
// Testbench of the I2C bit-level master: directed table, then random ticks at several phase
// lengths, each result checked against an in-bench model of the phase sequencer or a typed row.
// Depends on i2cbb_pkg and the i2c_bit_bang_master RTL.
module tb_i2c_bit_bang_master
	import i2cbb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 1000;

	typedef struct packed {
		logic       scl_level;
		logic       scl_drive;
		logic       sda_level;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic       ack_wait;
		logic [7:0] rdata;
	} tick_result_t;

	typedef struct {
		op_t          op;
		logic [7:0]   wd;
		logic         sda;
		int           follow;
		bit           typed;
		tick_result_t want;
	} dir_row_t;

	localparam tick_result_t RES_IDLE = '0;
	localparam tick_result_t RES_START_FIRST = '{scl_level: 1'b0, scl_drive: 1'b0,
		sda_level: 1'b1, sda_drive: 1'b0, busy: 1'b1, done: 1'b0, ack_wait: 1'b0,
		rdata: 8'h00};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] operation;
	logic [7:0] write_data;
	logic       sda_in;
	logic       out_valid;
	logic       out_stall;
	logic       scl_level;
	logic       scl_drive;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic       ack_waiting;
	logic [7:0] read_data;

	i2c_bit_bang_master i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl_level   (scl_level),
		.scl_drive   (scl_drive),
		.sda_level   (sda_level),
		.sda_drive   (sda_drive),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.ack_waiting (ack_waiting),
		.read_data   (read_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Engine model state.
	op_t        eng_cmd;
	logic [2:0] eng_phase;
	logic [3:0] eng_bits;
	logic [7:0] eng_ticks;
	logic [7:0] eng_shift;
	logic [7:0] eng_read;
	logic [7:0] eng_len;
	pins_t      eng_pins;

	tick_result_t expected_ticks [$];
	int unsigned  mismatches;
	int unsigned  n_requests;
	int unsigned  n_results;
	int unsigned  cmds_taken;
	int unsigned  ack_holds;
	int unsigned  idle_cycles;
	int           stall_left;
	bit           idling_on;

	dir_row_t dir_rows [$] = '{
		'{OP_NONE,    8'h00, 1'b1, 0,  1'b1, RES_IDLE},
		'{OP_START,   8'h00, 1'b1, 4,  1'b1, RES_START_FIRST},
		'{OP_STOP,    8'h00, 1'b1, 0,  1'b0, RES_IDLE},
		'{OP_WRITE,   8'hFF, 1'b0, 23, 1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b0, 0,  1'b0, RES_IDLE},
		'{OP_WRITE,   8'h00, 1'b1, 5,  1'b0, RES_IDLE},
		'{OP_READ,    8'h00, 1'b1, 17, 1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b1, 0,  1'b0, RES_IDLE},
		'{OP_READ,    8'h00, 1'b1, 25, 1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b1, 0,  1'b0, RES_IDLE},
		'{OP_READ,    8'h00, 1'b0, 25, 1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b0, 0,  1'b0, RES_IDLE},
		'{OP_ACK,     8'h00, 1'b1, 10, 1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b0, 1,  1'b0, RES_IDLE},
		'{OP_ACK,     8'h00, 1'b0, 4,  1'b0, RES_IDLE},
		'{OP_NACK,    8'hA5, 1'b1, 2,  1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b1, 0,  1'b0, RES_IDLE},
		'{OP_RESTART, 8'h5A, 1'b1, 3,  1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b1, 0,  1'b0, RES_IDLE},
		'{OP_START,   8'h00, 1'b0, 4,  1'b0, RES_IDLE},
		'{OP_NONE,    8'h00, 1'b0, 0,  1'b0, RES_IDLE}
	};

	logic [7:0] len_plan   [6] = '{8'd3, 8'd0, 8'd2, 8'd255, 8'd5, 8'd1};
	int         count_plan [6] = '{300, 250, 250, 100, 250, 350};

	function automatic void apply_action(logic sda);
		logic [2:0] bitpos;
		logic       mid;
		bitpos = TOP_BIT - eng_bits[2:0];
		mid = (eng_cmd == OP_RESTART);
		case (eng_cmd)
			OP_START: begin
				case (eng_phase)
					3'd0: eng_pins.sda_lvl = 1'b1;
					3'd1: eng_pins.scl_lvl = 1'b1;
					3'd2: eng_pins.sda_drv = 1'b1;
					3'd3: eng_pins.scl_drv = 1'b1;
					default: eng_pins.sda_lvl = 1'b0;
				endcase
			end
			OP_RESTART, OP_STOP: begin
				case (eng_phase)
					3'd0: eng_pins.scl_lvl = 1'b0;
					3'd1: eng_pins.sda_lvl = mid;
					3'd2: eng_pins.scl_lvl = 1'b1;
					default: eng_pins.sda_lvl = !mid;
				endcase
			end
			OP_NACK: begin
				case (eng_phase)
					3'd0: eng_pins.scl_lvl = 1'b0;
					3'd1: eng_pins.sda_lvl = 1'b1;
					default: eng_pins.scl_lvl = 1'b1;
				endcase
			end
			OP_WRITE: begin
				case (eng_phase)
					3'd0: eng_pins.scl_lvl = 1'b0;
					3'd1: eng_pins.sda_lvl = eng_shift[bitpos];
					default: eng_pins.scl_lvl = 1'b1;
				endcase
			end
			OP_READ: begin
				case (eng_phase)
					3'd0: eng_pins.sda_drv = 1'b0;
					3'd1: eng_pins.scl_lvl = 1'b0;
					3'd2: eng_pins.scl_lvl = 1'b1;
					3'd3: eng_shift[bitpos] = sda;
					default: eng_pins.sda_drv = 1'b1;
				endcase
			end
			OP_ACK: begin
				case (eng_phase)
					3'd0: eng_pins.scl_lvl = 1'b0;
					3'd1: eng_pins.sda_lvl = 1'b1;
					3'd2: eng_pins.sda_drv = 1'b0;
					3'd3: eng_pins.scl_lvl = 1'b1;
					ACK_DONE_PHASE: eng_pins.sda_drv = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	function automatic bit next_phase();
		bit more;
		more = 1'b1;
		case (eng_cmd)
			OP_WRITE: begin
				if (eng_phase >= 3'd2) begin
					eng_phase = 3'd0;
					eng_bits = eng_bits + 4'd1;
					return eng_bits < BITS_PER_BYTE;
				end
			end
			OP_READ: begin
				if (eng_phase == 3'd3) begin
					eng_bits = eng_bits + 4'd1;
					eng_phase = (eng_bits < BITS_PER_BYTE) ? 3'd1 : READ_END_PHASE;
					return 1'b1;
				end
				more = eng_phase < READ_END_PHASE;
			end
			OP_START: more = eng_phase < 3'd4;
			OP_RESTART, OP_STOP: more = eng_phase < 3'd3;
			OP_NACK: more = eng_phase < 3'd2;
			OP_ACK: more = eng_phase < ACK_DONE_PHASE;
			default: more = 1'b0;
		endcase
		if (more)
			eng_phase = eng_phase + 3'd1;
		return more;
	endfunction

	function automatic void enter_phase(logic sda);
		eng_ticks = '0;
		apply_action(sda);
		if (eng_cmd == OP_ACK && eng_phase == ACK_WAIT_PHASE && !sda) begin
			eng_phase = ACK_DONE_PHASE;
			apply_action(sda);
		end
	endfunction

	function automatic tick_result_t engine_tick(op_t op, logic [7:0] wd, logic sda);
		tick_result_t r;
		logic [8:0]   t;
		logic [7:0]   len;
		logic         done;
		len = (eng_len == 8'd0) ? 8'd1 : eng_len;
		done = 1'b0;
		if (eng_cmd == OP_NONE) begin
			if (op != OP_NONE) begin
				eng_cmd = op;
				eng_phase = '0;
				eng_bits = '0;
				cmds_taken++;
				if (op == OP_WRITE)
					eng_shift = wd;
				enter_phase(sda);
			end
		end else if (eng_cmd == OP_ACK && eng_phase == ACK_WAIT_PHASE) begin
			ack_holds++;
			if (!sda) begin
				eng_phase = ACK_DONE_PHASE;
				eng_ticks = '0;
				apply_action(sda);
			end
		end else begin
			t = {1'b0, eng_ticks} + 9'd1;
			if (t >= {1'b0, len}) begin
				if (next_phase()) begin
					enter_phase(sda);
				end else begin
					if (eng_cmd == OP_READ)
						eng_read = eng_shift;
					eng_cmd = OP_NONE;
					eng_phase = '0;
					eng_bits = '0;
					eng_ticks = '0;
					done = 1'b1;
				end
			end else begin
				eng_ticks = t[7:0];
			end
		end
		r.scl_level = eng_pins.scl_lvl;
		r.scl_drive = eng_pins.scl_drv;
		r.sda_level = eng_pins.sda_lvl;
		r.sda_drive = eng_pins.sda_drv;
		r.busy = (eng_cmd != OP_NONE);
		r.done = done;
		r.ack_wait = (eng_cmd == OP_ACK && eng_phase == ACK_WAIT_PHASE);
		r.rdata = eng_read;
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("mismatch in result %0d: %s is %0h, expected %0h", n_results, field, got,
			want);
		mismatches++;
	endtask

	task automatic send_request(op_t op, logic [7:0] wd, logic sda, bit typed,
			tick_result_t want);
		tick_result_t pred;
		in_valid <= 1'b1;
		operation <= op;
		write_data <= wd;
		sda_in <= sda;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = engine_tick(op, wd, sda);
		expected_ticks.push_back(typed ? want : pred);
		n_requests++;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15))
				@(negedge clk);
		end
	endtask

	task automatic set_phase_length(logic [7:0] len);
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		eng_len = len;
	endtask

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				note_mismatch("unexpected result", read_data, 8'h00);
			end else begin
				want = expected_ticks.pop_front();
				if (scl_level !== want.scl_level)
					note_mismatch("scl_level", 8'(scl_level), 8'(want.scl_level));
				if (scl_drive !== want.scl_drive)
					note_mismatch("scl_drive", 8'(scl_drive), 8'(want.scl_drive));
				if (sda_level !== want.sda_level)
					note_mismatch("sda_level", 8'(sda_level), 8'(want.sda_level));
				if (sda_drive !== want.sda_drive)
					note_mismatch("sda_drive", 8'(sda_drive), 8'(want.sda_drive));
				if (busy_res !== want.busy)
					note_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
				if (done_res !== want.done)
					note_mismatch("done_res", 8'(done_res), 8'(want.done));
				if (ack_waiting !== want.ack_wait)
					note_mismatch("ack_waiting", 8'(ack_waiting), 8'(want.ack_wait));
				if (read_data !== want.rdata)
					note_mismatch("read_data", read_data, want.rdata);
			end
			n_results++;
		end
	end

	always @(negedge clk) begin
		if (!idling_on) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		op_t        op;
		logic [7:0] wd;
		logic       sda;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		operation = OP_NONE;
		write_data = '0;
		sda_in = 1'b1;
		out_stall = 1'b0;
		stall_left = 0;
		idling_on = 1'b1;
		idle_cycles = 0;
		mismatches = 0;
		n_requests = 0;
		n_results = 0;
		cmds_taken = 0;
		ack_holds = 0;
		eng_cmd = OP_NONE;
		eng_phase = '0;
		eng_bits = '0;
		eng_ticks = '0;
		eng_shift = '0;
		eng_read = '0;
		eng_len = 8'd1;
		eng_pins = '0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].op, dir_rows[i].wd, dir_rows[i].sda, dir_rows[i].typed,
				dir_rows[i].want);
			repeat (dir_rows[i].follow)
				send_request(OP_NONE, 8'h00, dir_rows[i].sda, 1'b0, RES_IDLE);
		end

		foreach (len_plan[p]) begin
			set_phase_length(len_plan[p]);
			if (p == $size(len_plan) - 1)
				idling_on = 1'b0;
			repeat (count_plan[p]) begin
				if (eng_cmd == OP_NONE)
					op = ($urandom_range(0, 9) < 8) ? op_t'($urandom_range(1, 7)) : OP_NONE;
				else
					op = ($urandom_range(0, 9) == 0) ? op_t'($urandom_range(0, 7)) : OP_NONE;
				wd = 8'($urandom_range(0, 255));
				if (eng_cmd == OP_ACK && eng_phase == ACK_WAIT_PHASE)
					sda = ($urandom_range(0, 9) < 7);
				else
					sda = 1'($urandom_range(0, 1));
				send_request(op, wd, sda, 1'b0, RES_IDLE);
			end
		end

		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		$display("Ran %0d requests and checked %0d results over %0d phase-length settings.",
			n_requests, n_results, $size(len_plan) + 1);
		$display("The engine took %0d commands and held %0d ticks waiting for acknowledge.",
			cmds_taken, ack_holds);
		if (mismatches == 0 && expected_ticks.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2cbb_pkg.sv
rtl/core/i2c_bit_bang_master.sv
rtl/core/i2cbb_checker.sv
verif/tb_i2c_bit_bang_master.sv
